// ===== rtl/xxrb_pkg.sv =====
// shared constants and types for the xon/xoff receive ring buffer
package xxrb_pkg;

    localparam int RING_DEPTH = 8;
    localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int THR_W      = 4;
    localparam int CMP_W      = (CNT_W > THR_W) ? CNT_W : THR_W;

    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CTRL_LIMIT = 8'd32;

    localparam logic [1:0] FLOW_NONE = 2'd0;
    localparam logic [1:0] FLOW_XOFF = 2'd1;
    localparam logic [1:0] FLOW_XON  = 2'd2;

    localparam logic OP_RECEIVE = 1'b0;
    localparam logic OP_POP     = 1'b1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_CODE        = 2'd2;

    localparam logic [THR_W-1:0] UPPER_RESET    = 4'd6;
    localparam logic [THR_W-1:0] LOWER_RESET    = 4'd2;
    localparam logic [7:0]       END_CODE_RESET = 8'd26;

    // result word, last field in the lowest bits
    typedef struct packed {
        logic [1:0] pad;
        logic [1:0] flow_send;
        logic       end_seen;
        logic [7:0] pop_byte;
        logic       pop_valid;
        logic       overflow;
        logic       accepted;
    } xxrb_result_t;

    localparam int RESULT_W = $bits(xxrb_result_t);

    function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == IDX_W'(RING_DEPTH - 1))
            r = '0;
        else
            r = i + 1'b1;
        return r;
    endfunction

endpackage

// ===== rtl/xon_xoff_receive_ring_buffer.sv =====
// xon/xoff receive ring buffer top level with ring memory and control sequencer
//
//  channel  | direction | handshake                     | payload
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | tuser: opcode, tdata: rx_byte
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata: result fields
//  cfg      | in        | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// a receive runs ST_IDLE, ST_HOLD; a pop adds ST_READ if the ring holds data; k ring
// reads, one per cycle through the single read port of the ring memory (k <= 8)
// reset clears indexes, fill count, pause flag and restores register defaults
// one item is in work at a time; a new item is taken while a result waits at m_axis
// a result that cannot enter the output register holds the sequencer until it can
module xon_xoff_receive_ring_buffer
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]                     s_axis_tuser,   // [0] opcode
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] accepted, [1] overflow, [2] pop_valid, [10:3] pop_byte,
    // [11] end_seen, [13:12] flow_send, [15:14] zero
    output logic [xxrb_pkg::RESULT_W-1:0]  m_axis_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [xxrb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);
    import xxrb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_HOLD
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             paused_reg, paused_next;
    xxrb_result_t     res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    xxrb_result_t     out_data_reg, out_data_next;
    logic [THR_W-1:0] upper_reg;
    logic [THR_W-1:0] lower_reg;
    logic [7:0]       end_code_reg;

    logic [7:0]       ring [RING_DEPTH];
    logic [7:0]       rd_data_reg;
    logic             wr_en;
    logic             rd_en;

    logic             in_xfer;
    logic [CNT_W-1:0] cnt_after;
    logic             ctrl_byte;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

    assign cnt_after = cnt_reg + 1'b1;
    assign ctrl_byte = (rd_data_reg < CTRL_LIMIT) && (rd_data_reg != CHAR_LF);

    always_comb
    begin
        state_next     = state_reg;
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        cnt_next       = cnt_reg;
        paused_next    = paused_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    res_next   = '0;
                    state_next = ST_HOLD;
                    if (s_axis_tuser[0] == OP_RECEIVE)
                    begin
                        if (!paused_reg)
                        begin
                            if (cnt_reg == CNT_W'(RING_DEPTH))
                            begin
                                res_next.overflow = 1'b1;
                                if (CMP_W'(cnt_reg) > CMP_W'(upper_reg))
                                begin
                                    paused_next        = 1'b1;
                                    res_next.flow_send = FLOW_XOFF;
                                end
                            end
                            else
                            begin
                                wr_en             = 1'b1;
                                wr_idx_next       = next_index(wr_idx_reg);
                                cnt_next          = cnt_after;
                                res_next.accepted = 1'b1;
                                if (CMP_W'(cnt_after) > CMP_W'(upper_reg))
                                begin
                                    paused_next        = 1'b1;
                                    res_next.flow_send = FLOW_XOFF;
                                end
                            end
                        end
                    end
                    else if (cnt_reg != '0)
                    begin
                        rd_en       = 1'b1;
                        rd_idx_next = next_index(rd_idx_reg);
                        cnt_next    = cnt_reg - 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // skip control bytes while the ring still holds data
                if (ctrl_byte && cnt_reg != '0)
                begin
                    rd_en       = 1'b1;
                    rd_idx_next = next_index(rd_idx_reg);
                    cnt_next    = cnt_reg - 1'b1;
                end
                else
                begin
                    res_next.pop_valid = 1'b1;
                    res_next.pop_byte  = rd_data_reg;
                    res_next.end_seen  = (rd_data_reg == end_code_reg);
                    if ((CMP_W'(cnt_reg) < CMP_W'(lower_reg)) && paused_reg)
                    begin
                        paused_next        = 1'b0;
                        res_next.flow_send = FLOW_XON;
                    end
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            cnt_reg       <= '0;
            paused_reg    <= 1'b0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            cnt_reg       <= cnt_next;
            paused_reg    <= paused_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg    <= UPPER_RESET;
            lower_reg    <= LOWER_RESET;
            end_code_reg <= END_CODE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_UPPER_THRESHOLD: upper_reg    <= cfg_data[THR_W-1:0];
                REG_LOWER_THRESHOLD: lower_reg    <= cfg_data[THR_W-1:0];
                REG_END_CODE:        end_code_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // ring memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            ring[wr_idx_reg] <= s_axis_tdata;
        if (rd_en)
            rd_data_reg <= ring[rd_idx_reg];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(RING_DEPTH))
        else $error("fill count beyond ring depth");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("second item taken while one is in work");

    a_xoff_on_pause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(paused_reg) |-> res_reg.flow_send == FLOW_XOFF)
        else $error("pause entered without xoff request");

    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !((m_axis_tdata[0] || m_axis_tdata[1]) && m_axis_tdata[2]))
        else $error("receive and pop flags mixed in one result");

endmodule
